// ----- hdl/lc3x_pkg.sv -----
`default_nettype none

package lc3x_pkg;

    // Word memory address width and depth.
    localparam int unsigned MEM_ADDR_BITS = 16;
    localparam int unsigned MEM_DEPTH     = 1 << MEM_ADDR_BITS;

    localparam int unsigned RF_DEPTH = 8;

    typedef logic [15:0] t_word;

    // Item kinds.
    localparam logic [1:0] K_EXEC  = 2'd0;
    localparam logic [1:0] K_MEMWR = 2'd1;
    localparam logic [1:0] K_SETPC = 2'd2;

    // LC-3 opcodes handled here.
    localparam logic [3:0] OP_BR  = 4'h0;
    localparam logic [3:0] OP_ADD = 4'h1;
    localparam logic [3:0] OP_LD  = 4'h2;
    localparam logic [3:0] OP_JSR = 4'h4;
    localparam logic [3:0] OP_AND = 4'h5;
    localparam logic [3:0] OP_LDR = 4'h6;
    localparam logic [3:0] OP_NOT = 4'h9;
    localparam logic [3:0] OP_LDI = 4'hA;
    localparam logic [3:0] OP_JMP = 4'hC;
    localparam logic [3:0] OP_LEA = 4'hE;

    // Condition codes.
    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    localparam t_word PC_RESET = 16'h3000;

    localparam logic [2:0] LINK_REG = 3'd7;

    typedef struct packed {
        t_word      pc;
        logic [2:0] cond;
        logic       reg_write_valid;
        logic [2:0] reg_index;
        t_word      reg_value;
        logic       status;
    } t_result;

    function automatic logic [2:0] cc_of(input t_word v);
        logic [2:0] cc;
        if (v == 16'd0) begin
            cc = CC_Z;
        end else if (v[15]) begin
            cc = CC_N;
        end else begin
            cc = CC_P;
        end
        return cc;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lc3x_in_if.sv -----
`default_nettype none

interface lc3x_in_if;
    import lc3x_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    t_word      instruction;
    t_word      address;
    t_word      data;

    modport source(output valid, output kind, output instruction, output address,
                   output data, input ready);
    modport sink(input valid, input kind, input instruction, input address,
                 input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lc3x_out_if.sv -----
`default_nettype none

interface lc3x_out_if;
    import lc3x_pkg::*;

    logic       valid;
    logic       ready;
    t_word      pc;
    logic [2:0] cond;
    logic       reg_write_valid;
    logic [2:0] reg_index;
    t_word      reg_value;
    logic       status;

    modport source(output valid, output pc, output cond, output reg_write_valid,
                   output reg_index, output reg_value, output status, input ready);
    modport sink(input valid, input pc, input cond, input reg_write_valid,
                 input reg_index, input reg_value, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/lc3x_ram.sv -----
`default_nettype none

module lc3x_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/lc3_instruction_execute_core.sv -----
// Throughput: one item per cycle for ALU, branch, jump, LEA, preload and set-PC items while
// the output is not stalled; LD and LDR also pass through MEM1, and LDI through MEM1 and MEM2,
// set by the registered read port of the word memory. The result is loaded into the output
// register at the end of its last work state, once the output register is free.
// Reset (synchronous, active low): PC is 0x3000, the condition code is Z, all general
// registers read as zero through per-register valid bits, and the word memory is not cleared.
`default_nettype none

module lc3_instruction_execute_core (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lc3x_in_if.sink   i_in,
    lc3x_out_if.source o_out
);
    import lc3x_pkg::*;

    localparam int unsigned RF_AW = $clog2(RF_DEPTH);

    // Sequencer states. An item is registered in IDLE or at the end of another item,
    // does its decode and ALU work in EXEC, and spends MEM1/MEM2 on memory reads.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MEM1 = 2'd2;
    localparam logic [1:0] S_MEM2 = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_kind;
    t_word               r_ins;
    t_word               r_addr;
    t_word               r_data;
    t_word               r_pc;
    logic [2:0]          r_cc;
    logic [RF_DEPTH-1:0] r_rf_vld;
    logic                r_byp_vld;
    logic [RF_AW-1:0]    r_byp_idx;
    t_word               r_byp_val;
    logic                r_out_vld;
    t_result             r_out;

    logic     in_acc;
    logic     out_free;
    logic     done;
    logic     set_cc;
    t_result  res;
    t_word    rf_a_q, rf_b_q, mem_q;
    t_word    opa, opb, opb_alu;
    t_word    pc_inc;
    t_word    off9, off6, off11, imm5;
    t_word    ld_addr;
    logic     mem_re, mem_we;
    t_word    mem_raddr;
    logic [3:0]       op;
    logic [RF_AW-1:0] dr, sr1, sr2;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;

    // A new item may enter when the sequencer is empty or finishes its current item
    // in this cycle; the result register decouples us from a stalled consumer.
    assign i_in.ready = (r_state == S_IDLE) || done;

    // Register file: two copies written together, one per source operand.
    lc3x_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (done && res.reg_write_valid),
        .i_waddr (res.reg_index),
        .i_wdata (res.reg_value),
        .i_re    (in_acc),
        .i_raddr (i_in.instruction[8:6]),
        .o_rdata (rf_a_q)
    );

    lc3x_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (done && res.reg_write_valid),
        .i_waddr (res.reg_index),
        .i_wdata (res.reg_value),
        .i_re    (in_acc),
        .i_raddr (i_in.instruction[2:0]),
        .o_rdata (rf_b_q)
    );

    lc3x_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr[MEM_ADDR_BITS-1:0]),
        .i_wdata (r_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr[MEM_ADDR_BITS-1:0]),
        .o_rdata (mem_q)
    );

    assign op  = r_ins[15:12];
    assign dr  = r_ins[11:9];
    assign sr1 = r_ins[8:6];
    assign sr2 = r_ins[2:0];

    // The register file is read at the accept edge, which may be the same edge at which
    // the previous item writes it; the last write is held in a bypass register to cover
    // that case. A register never written reads as zero.
    always_comb begin
        if (r_byp_vld && (r_byp_idx == sr1)) begin
            opa = r_byp_val;
        end else if (r_rf_vld[sr1]) begin
            opa = rf_a_q;
        end else begin
            opa = 16'd0;
        end
        if (r_byp_vld && (r_byp_idx == sr2)) begin
            opb = r_byp_val;
        end else if (r_rf_vld[sr2]) begin
            opb = rf_b_q;
        end else begin
            opb = 16'd0;
        end
    end

    assign pc_inc  = r_pc + 16'd1;
    assign off9    = {{7{r_ins[8]}}, r_ins[8:0]};
    assign off6    = {{10{r_ins[5]}}, r_ins[5:0]};
    assign off11   = {{5{r_ins[10]}}, r_ins[10:0]};
    assign imm5    = {{11{r_ins[4]}}, r_ins[4:0]};
    assign opb_alu = r_ins[5] ? imm5 : opb;
    assign ld_addr = (op == OP_LDR) ? (opa + off6) : (pc_inc + off9);

    always_comb begin
        n_state   = r_state;
        done      = 1'b0;
        set_cc    = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = ld_addr;
        res.pc              = r_pc;
        res.cond            = r_cc;
        res.reg_write_valid = 1'b0;
        res.reg_index       = '0;
        res.reg_value       = 16'd0;
        res.status          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                done = out_free;
                case (r_kind)
                    K_EXEC: begin
                        res.pc = pc_inc;
                        case (op)
                            OP_ADD, OP_AND: begin
                                res.reg_write_valid = 1'b1;
                                res.reg_index       = dr;
                                res.reg_value       = (op == OP_ADD) ? (opa + opb_alu)
                                                                     : (opa & opb_alu);
                                set_cc              = 1'b1;
                            end
                            OP_NOT: begin
                                res.reg_write_valid = 1'b1;
                                res.reg_index       = dr;
                                res.reg_value       = ~opa;
                                set_cc              = 1'b1;
                            end
                            OP_BR: begin
                                if ((r_ins[11:9] & r_cc) != 3'd0) begin
                                    res.pc = pc_inc + off9;
                                end
                            end
                            OP_JMP: begin
                                res.pc = opa;
                            end
                            OP_JSR: begin
                                res.pc              = r_ins[11] ? (pc_inc + off11) : opa;
                                res.reg_write_valid = 1'b1;
                                res.reg_index       = LINK_REG;
                                res.reg_value       = pc_inc;
                            end
                            OP_LEA: begin
                                res.reg_write_valid = 1'b1;
                                res.reg_index       = dr;
                                res.reg_value       = pc_inc + off9;
                                set_cc              = 1'b1;
                            end
                            OP_LD, OP_LDI, OP_LDR: begin
                                // First memory read; the result comes later.
                                done    = 1'b0;
                                mem_re  = 1'b1;
                                n_state = S_MEM1;
                            end
                            default: begin
                                res.status = 1'b1;
                            end
                        endcase
                    end
                    K_MEMWR: begin
                        mem_we = out_free;
                    end
                    K_SETPC: begin
                        res.pc = r_data;
                    end
                    default: begin
                        res.status = 1'b1;
                    end
                endcase
            end
            S_MEM1: begin
                // For LDI the word just read is the address of the operand.
                mem_raddr = mem_q;
                if (op == OP_LDI) begin
                    mem_re  = 1'b1;
                    n_state = S_MEM2;
                end else begin
                    done                = out_free;
                    res.pc              = pc_inc;
                    res.reg_write_valid = 1'b1;
                    res.reg_index       = dr;
                    res.reg_value       = mem_q;
                    set_cc              = 1'b1;
                end
            end
            S_MEM2: begin
                mem_raddr           = mem_q;
                done                = out_free;
                res.pc              = pc_inc;
                res.reg_write_valid = 1'b1;
                res.reg_index       = dr;
                res.reg_value       = mem_q;
                set_cc              = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (set_cc) begin
            res.cond = cc_of(res.reg_value);
        end

        if (done) begin
            n_state = in_acc ? S_EXEC : S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= PC_RESET;
            r_cc      <= CC_Z;
            r_rf_vld  <= '0;
            r_byp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_pc      <= res.pc;
                r_cc      <= res.cond;
                r_out_vld <= 1'b1;
                if (res.reg_write_valid) begin
                    r_rf_vld[res.reg_index] <= 1'b1;
                    r_byp_vld               <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_in.kind;
            r_ins  <= i_in.instruction;
            r_addr <= i_in.address;
            r_data <= i_in.data;
        end
        if (done) begin
            r_out <= res;
            if (res.reg_write_valid) begin
                r_byp_idx <= res.reg_index;
                r_byp_val <= res.reg_value;
            end
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.pc              = r_out.pc;
    assign o_out.cond            = r_out.cond;
    assign o_out.reg_write_valid = r_out.reg_write_valid;
    assign o_out.reg_index       = r_out.reg_index;
    assign o_out.reg_value       = r_out.reg_value;
    assign o_out.status          = r_out.status;

    // The condition code always holds exactly one of N, Z and P.
    a_cc_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_cc))
        else $error("condition code is not one-hot");

    // No new item is taken while an indirect load still waits for its second read.
    a_no_accept_in_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEM1 && op == OP_LDI) |-> !i_in.ready)
        else $error("item accepted during an indirect load");

    // An accepted item is always decoded in the next cycle.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted item did not reach execute");

    // A result without a register write carries a zero index and value.
    a_clean_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.reg_write_valid) |->
            (r_out.reg_index == '0 && r_out.reg_value == 16'd0))
        else $error("stale register fields in result");

    // An unsupported item never writes a register.
    a_status_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status) |-> !r_out.reg_write_valid)
        else $error("unsupported item wrote a register");

endmodule

`default_nettype wire
